// ===== rtl/mmu_pkg.sv =====
// Shared widths, codes and pipeline tag type for the matrix multiply unit.
package mmu_pkg;

  localparam int MAX_DIM_DEF = 8;

  localparam int DIM_W  = 4;
  localparam int IDX_W  = 3;
  localparam int ELEM_W = 16;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int VAL_W  = 35;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;
  localparam int FUNC_W      = 2;
  localparam int CFG_ADDR_W  = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WR_A    = 2'd0,
    FUNC_WR_B    = 2'd1,
    FUNC_COMPUTE = 2'd2
  } func_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ROWS_A = 2'd0,
    CFG_COLS_A = 2'd1,
    CFG_ROWS_B = 2'd2,
    CFG_COLS_B = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_NEXT  = 4'b0010,
    ST_ISSUE = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_e;

  // Travels alongside each multiply-accumulate step through the pipeline.
  typedef struct packed {
    logic             first_k;
    logic             last_k;
    logic             last_elem;
    logic             zero;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

endpackage

// ===== rtl/mmu_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module mmu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/matrix_multiply_unit.sv =====
// Matrix multiply unit: two element stores and a multiply-accumulate sequencer.
//
// Load requests write one element of A or B and are taken back to back while the
// unit is idle. A compute request walks C in row-major order; each element takes
// as many multiply-accumulate steps as the effective inner dimension (cols_a, or
// a single step when the dimensions mismatch or the inner dimension is zero), with
// the single read port of each store delivering one A and one B element per cycle;
// the read/multiply/accumulate pipeline drains before the next element starts, and
// each element also waits until the result at the output has been taken.
// While a compute request runs, no new request is taken, so the stores are never
// written and read at the same time. Stores hold nothing useful until written.
module matrix_multiply_unit
  import mmu_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input requests.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: row_index[2:0], col_index[5:3], elem_value[21:6], zero pad [23:22]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: func[1:0]
  input  logic [FUNC_W-1:0]      s_axis_tuser,
  // Product elements.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: out_row[2:0], out_col[5:3], out_value[40:6], zero pad [47:41]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,
  // tuser: dim_error[0]
  output logic                   m_axis_tuser,
  // Configuration writes.
  input  logic                   cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [DIM_W-1:0]       cfg_wdata_i
);

  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AddrW = $clog2(Depth);
  localparam int IdxW  = $clog2(MAX_DIM);
  localparam logic [DIM_W-1:0] MaxDimV = DIM_W'(MAX_DIM);

  // Configuration registers.
  logic [DIM_W-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= DIM_W'(1);
      cols_a_q <= DIM_W'(1);
      rows_b_q <= DIM_W'(1);
      cols_b_q <= DIM_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_ROWS_A: rows_a_q <= cfg_wdata_i;
        CFG_COLS_A: cols_a_q <= cfg_wdata_i;
        CFG_ROWS_B: rows_b_q <= cfg_wdata_i;
        CFG_COLS_B: cols_b_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] m_dim, n_dim, inner_dim, rows_b_dim, k_count;
  logic             mismatch, zero_sum;

  always_comb begin
    m_dim      = (rows_a_q > MaxDimV) ? MaxDimV : rows_a_q;
    inner_dim  = (cols_a_q > MaxDimV) ? MaxDimV : cols_a_q;
    rows_b_dim = (rows_b_q > MaxDimV) ? MaxDimV : rows_b_q;
    n_dim      = (cols_b_q > MaxDimV) ? MaxDimV : cols_b_q;
    mismatch   = (inner_dim != rows_b_dim);
    // With a mismatch or an empty inner dimension each element is a single
    // step whose product is forced to zero.
    zero_sum   = mismatch || (inner_dim == '0);
    k_count    = zero_sum ? DIM_W'(1) : inner_dim;
  end

  // Input request decode.
  func_e             in_func;
  logic [IDX_W-1:0]  in_row, in_col;
  logic [ELEM_W-1:0] in_elem;
  logic              in_accept, in_range;

  assign in_func   = func_e'(s_axis_tuser);
  assign in_row    = s_axis_tdata[IDX_W-1:0];
  assign in_col    = s_axis_tdata[2*IDX_W-1:IDX_W];
  assign in_elem   = s_axis_tdata[2*IDX_W+ELEM_W-1:2*IDX_W];
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign in_range  = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);

  logic             a_we, b_we;
  logic [AddrW-1:0] waddr, a_raddr, b_raddr;

  always_comb begin
    a_we = 1'b0;
    b_we = 1'b0;
    case (in_func)
      FUNC_WR_A: a_we = in_accept && in_range;
      FUNC_WR_B: b_we = in_accept && in_range;
      default: ;
    endcase
  end

  assign waddr = AddrW'(int'(in_row) * MAX_DIM + int'(in_col));

  // Sequencer.
  state_e          state_q, state_d;
  logic [IdxW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic            out_free, k_last, i_last, j_last, issue;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign k_last   = (DIM_W'(k_q) == k_count - DIM_W'(1));
  assign i_last   = (DIM_W'(i_q) == m_dim - DIM_W'(1));
  assign j_last   = (DIM_W'(j_q) == n_dim - DIM_W'(1));
  assign issue    = (state_q == ST_ISSUE);

  assign a_raddr = AddrW'(int'(i_q) * MAX_DIM + int'(k_q));
  assign b_raddr = AddrW'(int'(k_q) * MAX_DIM + int'(j_q));

  // Pipeline: read stage, product stage, accumulate stage into acc_q; the final sum loads the output register.
  logic                     v1_q, v2_q;
  tag_t                     tag0, tag1_q, tag2_q;
  logic [ELEM_W-1:0]        a_rdata, b_rdata;
  logic signed [PROD_W-1:0] prod1;
  logic signed [PROD_W-1:0] prod2_q;
  logic signed [VAL_W-1:0]  acc_q, sum_w;
  logic                     land;

  assign land = v2_q && tag2_q.last_k;

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && in_func == FUNC_COMPUTE && m_dim != '0 && n_dim != '0) begin
          i_d     = '0;
          j_d     = '0;
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        // Start an element only once the output register is sure to be empty.
        if (out_free) begin
          k_d     = '0;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        k_d = k_q + IdxW'(1);
        if (k_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (land) begin
          if (i_last && j_last) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_NEXT;
            if (j_last) begin
              j_d = '0;
              i_d = i_q + IdxW'(1);
            end else begin
              j_d = j_q + IdxW'(1);
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  mmu_ram #(
    .WIDTH(ELEM_W),
    .DEPTH(Depth)
  ) u_a_store (
    .clk_i  (clk_i),
    .we_i   (a_we),
    .waddr_i(waddr),
    .wdata_i(in_elem),
    .raddr_i(a_raddr),
    .rdata_o(a_rdata)
  );

  mmu_ram #(
    .WIDTH(ELEM_W),
    .DEPTH(Depth)
  ) u_b_store (
    .clk_i  (clk_i),
    .we_i   (b_we),
    .waddr_i(waddr),
    .wdata_i(in_elem),
    .raddr_i(b_raddr),
    .rdata_o(b_rdata)
  );

  always_comb begin
    tag0.first_k   = (k_q == '0);
    tag0.last_k    = k_last;
    tag0.last_elem = i_last && j_last;
    tag0.zero      = zero_sum;
    tag0.row       = IDX_W'(i_q);
    tag0.col       = IDX_W'(j_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
    end
  end

  // The product is formed on its own so that it stays a signed multiply.
  assign prod1 = $signed(a_rdata) * $signed(b_rdata);

  always_ff @(posedge clk_i) begin
    tag1_q  <= tag0;
    tag2_q  <= tag1_q;
    prod2_q <= tag1_q.zero ? '0 : prod1;
  end

  assign sum_w = (tag2_q.first_k ? '0 : acc_q)
               + {{(VAL_W-PROD_W){prod2_q[PROD_W-1]}}, prod2_q};

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      acc_q <= sum_w;
    end
  end

  // Output register.
  logic                    out_valid_q;
  logic [IDX_W-1:0]        out_row_q, out_col_q;
  logic signed [VAL_W-1:0] out_value_q;
  logic                    out_last_q, out_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (land) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (land) begin
      out_row_q   <= tag2_q.row;
      out_col_q   <= tag2_q.col;
      out_value_q <= sum_w;
      out_last_q  <= tag2_q.last_elem;
      out_err_q   <= mismatch;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W-VAL_W-2*IDX_W)'(0), out_value_q, out_col_q, out_row_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_err_q;

  // A finished element must never land on a result that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    land |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwrote a pending output element");

  // The stores are only written while no compute request is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (!a_we && !b_we))
    else $error("store written during a compute request");

  // Each element finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    land |-> (state_q == ST_DRAIN))
    else $error("element finished outside the drain phase");

  // The inner counter stays within the step count of the element.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (DIM_W'(k_q) < k_count))
    else $error("inner step counter out of range");

endmodule
